/* rtl/core/trie_multi_pattern_matcher_top_defines.svh */
// ----------------------------------------------------------------------------
// Trie matcher assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIE_MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH
`define TRIE_MULTI_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define TMPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tmpm_pkg.sv */
// ----------------------------------------------------------------------------
// Trie matcher package
// Sizes, codes, state encoding and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package tmpm_pkg;

    localparam int NODE_COUNT      = 256;
    localparam int ALPHABET        = 26;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int MAX_PATTERNS    = 64;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int NUSED_W  = $clog2(NODE_COUNT + 1);
    localparam int LETTER_W = 5;
    localparam int TBL_DEPTH = NODE_COUNT * ALPHABET;
    localparam int TBL_AW   = $clog2(TBL_DEPTH);
    localparam int LANE_W   = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W    = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PAT_W    = 6;
    localparam int PCNT_W   = $clog2(MAX_PATTERNS + 1);
    localparam int POS_W    = 32;
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE      = 3'd0,
        KIND_MATCH     = 3'd1,
        KIND_NODE_FULL = 3'd2,
        KIND_TOO_LONG  = 3'd3,
        KIND_TOO_MANY  = 3'd4
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_EOT     = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_CHK,
        ST_LD_EVAL,
        ST_TX_SHIFT,
        ST_LN_CHK,
        ST_LN_CHILD,
        ST_LN_END,
        ST_LN_NEXT,
        ST_FIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic take;
        logic clr_start;
        logic kill_all;
        logic sweep;
        logic ld_rd;
        logic ld_fast;
        logic ld_eval;
        logic tx_shift;
        logic ln_rd;
        logic ln_skip;
        logic ln_child;
        logic ln_end;
        logic k_dec;
        logic fin;
        logic resp;
    } tmpm_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic clr_resp;
        logic ld_need_mem;
        logic lane_live;
        logic child_zero;
        logic hit;
        logic pend_valid;
        logic out_free;
        logic k_zero;
    } tmpm_stat_t;

endpackage
`default_nettype wire

/* rtl/core/tmpm_datapath.sv */
// ----------------------------------------------------------------------------
// Trie matcher datapath
// Trie tables, loader registers, lane chain, pending match and output word.
// ----------------------------------------------------------------------------
`default_nettype none
module tmpm_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tmpm_pkg::tmpm_cmd_t           cmd,
    output tmpm_pkg::tmpm_stat_t               stat,
    input  wire logic [tmpm_pkg::MODE_W-1:0]   in_mode,
    input  wire logic [tmpm_pkg::LETTER_W-1:0] in_letter,
    input  wire logic                          in_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tmpm_pkg::KIND_W-1:0]        out_kind,
    output logic [tmpm_pkg::POS_W-1:0]         out_start,
    output logic [tmpm_pkg::PAT_W-1:0]         out_pat,
    output logic                               out_last
);
    import tmpm_pkg::*;

    logic [NODE_W-1:0]      child_mem [TBL_DEPTH];
    logic [PAT_W:0]         end_mem   [NODE_COUNT];
    logic [NODE_W-1:0]      child_rdata_reg;
    logic [PAT_W:0]         end_rdata_reg;

    logic [TBL_AW-1:0]      sweep_addr_reg;
    logic                   clr_resp_reg;
    logic [LETTER_W-1:0]    letter_reg;
    logic                   pend_end_reg;
    logic [NUSED_W-1:0]     nodes_used_reg;
    logic [PCNT_W-1:0]      patterns_reg;
    logic [NODE_W-1:0]      load_node_reg;
    logic [LEN_W-1:0]       load_len_reg;
    kind_t                  fault_reg;
    kind_t                  result_kind_reg;
    logic [TBL_AW-1:0]      ld_addr_reg;

    logic                   lane_valid_reg [MAX_PATTERN_LEN];
    logic [NODE_W-1:0]      lane_node_reg  [MAX_PATTERN_LEN];
    logic [POS_W-1:0]       lane_start_reg [MAX_PATTERN_LEN];
    logic [POS_W-1:0]       text_pos_reg;
    logic [LANE_W-1:0]      k_reg;

    logic                   pend_valid_reg;
    logic [POS_W-1:0]       pend_start_reg;
    logic [PAT_W-1:0]       pend_pat_reg;

    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic [POS_W-1:0]       out_start_reg;
    logic [PAT_W-1:0]       out_pat_reg;
    logic                   out_last_reg;

    logic                   letter_ok;
    logic                   nodes_full;
    logic [NODE_W-1:0]      rd_node;
    logic [TBL_AW-1:0]      rd_addr;
    logic                   out_free;
    logic                   ld_new;

    assign letter_ok  = letter_reg < LETTER_W'(ALPHABET);
    assign nodes_full = nodes_used_reg >= NUSED_W'(NODE_COUNT);
    assign rd_node    = cmd.ln_rd ? lane_node_reg[k_reg] : load_node_reg;
    assign rd_addr    = TBL_AW'(rd_node) * TBL_AW'(ALPHABET) + TBL_AW'(letter_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign ld_new     = cmd.ld_eval && (child_rdata_reg == '0) && !nodes_full;

    always_comb
    begin
        stat.sweep_done  = sweep_addr_reg == TBL_AW'(TBL_DEPTH - 1);
        stat.clr_resp    = clr_resp_reg;
        stat.ld_need_mem = (fault_reg == KIND_DONE) && letter_ok
                           && (patterns_reg < PCNT_W'(MAX_PATTERNS))
                           && (load_len_reg < LEN_W'(MAX_PATTERN_LEN));
        stat.lane_live   = lane_valid_reg[k_reg] && letter_ok;
        stat.child_zero  = child_rdata_reg == '0;
        stat.hit         = end_rdata_reg[PAT_W];
        stat.pend_valid  = pend_valid_reg;
        stat.out_free    = out_free;
        stat.k_zero      = k_reg == '0;
    end

    // table memories
    always_ff @(posedge clk)
    begin
        child_rdata_reg <= child_mem[rd_addr];
        // end mark held while the lane waits on a busy output
        if (cmd.ln_child)
        begin
            end_rdata_reg <= end_mem[child_rdata_reg];
        end
        if (cmd.sweep)
        begin
            child_mem[sweep_addr_reg] <= '0;
            if (sweep_addr_reg < TBL_AW'(NODE_COUNT))
            begin
                end_mem[sweep_addr_reg[NODE_W-1:0]] <= '0;
            end
        end
        else
        begin
            if (ld_new)
            begin
                child_mem[ld_addr_reg] <= nodes_used_reg[NODE_W-1:0];
            end
            if (cmd.ld_eval && pend_end_reg && !((child_rdata_reg == '0) && nodes_full))
            begin
                end_mem[ld_new ? nodes_used_reg[NODE_W-1:0] : child_rdata_reg]
                    <= {1'b1, patterns_reg[PAT_W-1:0]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            letter_reg   <= in_letter;
            pend_end_reg <= in_end;
        end
        if (cmd.ld_rd)
        begin
            ld_addr_reg <= rd_addr;
        end
    end

    // control and loader state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg  <= '0;
            clr_resp_reg    <= 1'b0;
            nodes_used_reg  <= NUSED_W'(1);
            patterns_reg    <= '0;
            load_node_reg   <= '0;
            load_len_reg    <= '0;
            fault_reg       <= KIND_DONE;
            result_kind_reg <= KIND_DONE;
            text_pos_reg    <= '0;
            k_reg           <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++)
            begin
                lane_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_addr_reg <= sweep_addr_reg + TBL_AW'(1);
                if (stat.sweep_done)
                begin
                    clr_resp_reg <= 1'b0;
                end
            end

            if (cmd.clr_start)
            begin
                sweep_addr_reg  <= '0;
                clr_resp_reg    <= 1'b1;
                nodes_used_reg  <= NUSED_W'(1);
                patterns_reg    <= '0;
                load_node_reg   <= '0;
                load_len_reg    <= '0;
                fault_reg       <= KIND_DONE;
            end

            if (cmd.clr_start || cmd.kill_all)
            begin
                result_kind_reg <= KIND_DONE;
                text_pos_reg    <= '0;
                for (int i = 0; i < MAX_PATTERN_LEN; i++)
                begin
                    lane_valid_reg[i] <= 1'b0;
                end
            end

            if (cmd.ld_fast)
            begin
                if (fault_reg != KIND_DONE)
                begin
                    result_kind_reg <= fault_reg;
                    if (pend_end_reg)
                    begin
                        fault_reg     <= KIND_DONE;
                        load_node_reg <= '0;
                        load_len_reg  <= '0;
                    end
                end
                else if (patterns_reg >= PCNT_W'(MAX_PATTERNS))
                begin
                    result_kind_reg <= KIND_TOO_MANY;
                end
                else if (!letter_ok)
                begin
                    result_kind_reg <= KIND_DONE;
                end
                else
                begin
                    result_kind_reg <= KIND_TOO_LONG;
                    if (pend_end_reg)
                    begin
                        load_node_reg <= '0;
                        load_len_reg  <= '0;
                    end
                    else
                    begin
                        fault_reg <= KIND_TOO_LONG;
                    end
                end
            end

            if (cmd.ld_eval)
            begin
                if ((child_rdata_reg == '0) && nodes_full)
                begin
                    result_kind_reg <= KIND_NODE_FULL;
                    if (pend_end_reg)
                    begin
                        load_node_reg <= '0;
                        load_len_reg  <= '0;
                    end
                    else
                    begin
                        fault_reg <= KIND_NODE_FULL;
                    end
                end
                else
                begin
                    result_kind_reg <= KIND_DONE;
                    if (ld_new)
                    begin
                        nodes_used_reg <= nodes_used_reg + NUSED_W'(1);
                    end
                    if (pend_end_reg)
                    begin
                        patterns_reg  <= patterns_reg + PCNT_W'(1);
                        load_node_reg <= '0;
                        load_len_reg  <= '0;
                    end
                    else
                    begin
                        load_node_reg <= ld_new ? nodes_used_reg[NODE_W-1:0]
                                                : child_rdata_reg;
                        load_len_reg  <= load_len_reg + LEN_W'(1);
                    end
                end
            end

            if (cmd.tx_shift)
            begin
                for (int i = MAX_PATTERN_LEN - 1; i > 0; i--)
                begin
                    lane_valid_reg[i] <= lane_valid_reg[i-1];
                end
                lane_valid_reg[0] <= 1'b1;
                text_pos_reg      <= text_pos_reg + POS_W'(1);
                k_reg             <= LANE_W'(MAX_PATTERN_LEN - 1);
            end

            if (cmd.ln_skip || (cmd.ln_child && child_rdata_reg == '0))
            begin
                lane_valid_reg[k_reg] <= 1'b0;
            end

            if (cmd.k_dec)
            begin
                k_reg <= k_reg - LANE_W'(1);
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.resp || cmd.fin)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.ln_end && stat.hit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // lane payload and result words
    always_ff @(posedge clk)
    begin
        if (cmd.tx_shift)
        begin
            for (int i = MAX_PATTERN_LEN - 1; i > 0; i--)
            begin
                lane_node_reg[i]  <= lane_node_reg[i-1];
                lane_start_reg[i] <= lane_start_reg[i-1];
            end
            lane_node_reg[0]  <= '0;
            lane_start_reg[0] <= text_pos_reg;
        end
        if (cmd.ln_child)
        begin
            lane_node_reg[k_reg] <= child_rdata_reg;
        end
        if (cmd.ln_end && stat.hit)
        begin
            pend_start_reg <= lane_start_reg[k_reg];
            pend_pat_reg   <= end_rdata_reg[PAT_W-1:0];
            if (pend_valid_reg)
            begin
                out_kind_reg  <= KIND_MATCH;
                out_start_reg <= pend_start_reg;
                out_pat_reg   <= pend_pat_reg;
                out_last_reg  <= 1'b0;
            end
        end
        if (cmd.resp)
        begin
            out_kind_reg  <= result_kind_reg;
            out_start_reg <= '0;
            out_pat_reg   <= '0;
            out_last_reg  <= 1'b1;
        end
        if (cmd.fin)
        begin
            out_kind_reg  <= pend_valid_reg ? KIND_MATCH : KIND_DONE;
            out_start_reg <= pend_valid_reg ? pend_start_reg : '0;
            out_pat_reg   <= pend_valid_reg ? pend_pat_reg : '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_start = out_start_reg;
    assign out_pat   = out_pat_reg;
    assign out_last  = out_last_reg;

    logic unused_mode;
    assign unused_mode = ^in_mode;

endmodule
`default_nettype wire

/* rtl/core/tmpm_ctrl.sv */
// ----------------------------------------------------------------------------
// Trie matcher controller
// Sequences table sweep, pattern loads and the per-lane text walk.
// ----------------------------------------------------------------------------
`default_nettype none
module tmpm_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [tmpm_pkg::MODE_W-1:0] in_mode,
    output logic                             in_ready,
    input  wire tmpm_pkg::tmpm_stat_t        stat,
    output tmpm_pkg::tmpm_cmd_t              cmd
);
    import tmpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.sweep_done)
                begin
                    state_next = stat.clr_resp ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode_t'(in_mode))
                        MODE_CLEAR:   state_next = ST_CLEAR;
                        MODE_PATTERN: state_next = ST_LD_CHK;
                        MODE_TEXT:    state_next = ST_TX_SHIFT;
                        default:      state_next = ST_RESP;
                    endcase
                end
            end
            ST_LD_CHK:   state_next = stat.ld_need_mem ? ST_LD_EVAL : ST_RESP;
            ST_LD_EVAL:  state_next = ST_RESP;
            ST_TX_SHIFT: state_next = ST_LN_CHK;
            ST_LN_CHK:   state_next = stat.lane_live ? ST_LN_CHILD : ST_LN_NEXT;
            ST_LN_CHILD: state_next = stat.child_zero ? ST_LN_NEXT : ST_LN_END;
            ST_LN_END:
            begin
                if (!(stat.hit && stat.pend_valid && !stat.out_free))
                begin
                    state_next = ST_LN_NEXT;
                end
            end
            ST_LN_NEXT:  state_next = stat.k_zero ? ST_FIN : ST_LN_CHK;
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.sweep = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take      = 1'b1;
                    cmd.clr_start = mode_t'(in_mode) == MODE_CLEAR;
                    cmd.kill_all  = mode_t'(in_mode) == MODE_EOT;
                end
            end
            ST_LD_CHK:
            begin
                cmd.ld_rd   = stat.ld_need_mem;
                cmd.ld_fast = !stat.ld_need_mem;
            end
            ST_LD_EVAL:  cmd.ld_eval = 1'b1;
            ST_TX_SHIFT: cmd.tx_shift = 1'b1;
            ST_LN_CHK:
            begin
                cmd.ln_rd   = stat.lane_live;
                cmd.ln_skip = !stat.lane_live;
            end
            ST_LN_CHILD: cmd.ln_child = 1'b1;
            ST_LN_END:   cmd.ln_end = !(stat.hit && stat.pend_valid && !stat.out_free);
            ST_LN_NEXT:  cmd.k_dec = !stat.k_zero;
            ST_FIN:      cmd.fin = stat.out_free;
            ST_RESP:     cmd.resp = stat.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/trie_multi_pattern_matcher_top.sv */
// ----------------------------------------------------------------------------
// Trie multi-pattern matcher
// Builds a letter trie from loaded patterns and reports matches in text.
// ----------------------------------------------------------------------------
// One word at a time. A pattern letter passes a check state, an evaluate
// state when it needs the child table, and a response state. A text letter
// walks its 16 lanes oldest first through the single read port of the child
// table, a live lane also reading its child; a busy output can hold the
// walk. Reset and a clear word each sweep the 6656-entry child table,
// one entry a cycle, while s_axis_tready stays low. Matches of one letter
// leave in ascending start order; tlast marks the final word of each input word.
`default_nettype none
`include "trie_multi_pattern_matcher_top_defines.svh"
module trie_multi_pattern_matcher_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [4:0] letter
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
    input  wire logic        s_axis_tlast,  // pattern_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] start_position, [37:32] pattern_number
    output logic [2:0]       m_axis_tuser,  // [2:0] kind
    output logic             m_axis_tlast   // last
);
    import tmpm_pkg::*;

    tmpm_cmd_t             cmd;
    tmpm_stat_t            stat;
    logic [KIND_W-1:0]     out_kind;
    logic [POS_W-1:0]      out_start;
    logic [PAT_W-1:0]      out_pat;

    tmpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmpm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_mode   (s_axis_tuser),
        .in_letter (s_axis_tdata[LETTER_W-1:0]),
        .in_end    (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_start (out_start),
        .out_pat   (out_pat),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_pat, out_start};
    assign m_axis_tuser = out_kind;

    logic unused_tdata;
    assign unused_tdata = ^s_axis_tdata[7:LETTER_W];

    `TMPM_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while a word is in progress")
    `TMPM_ASSERT_NOW(a_mid_is_match, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser == KIND_MATCH, "non-final result is not a match")
    `TMPM_ASSERT_NOW(a_status_zero, m_axis_tvalid && m_axis_tuser != KIND_MATCH,
        m_axis_tdata == '0, "status result carries match fields")

endmodule
`default_nettype wire
